// ===== rtl/psmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Panel setup-mode controller package
// Shared codes, widths and the state, item and result structures.
// ----------------------------------------------------------------------------
package psmc_pkg;

  // Switch position codes. Code 3 means no valid position.
  localparam logic [1:0] SW_DOWN   = 2'd0;
  localparam logic [1:0] SW_MIDDLE = 2'd1;
  localparam logic [1:0] SW_UP     = 2'd2;

  // Flash kinds.
  localparam logic [1:0] FLASH_NONE  = 2'd0;
  localparam logic [1:0] FLASH_ENTER = 2'd1;
  localparam logic [1:0] FLASH_LEAVE = 2'd2;

  // Flash lengths in ticks.
  localparam logic [13:0] FLASH_ENTER_TICKS = 14'd7200;
  localparam logic [13:0] FLASH_LEAVE_TICKS = 14'd9600;

  // Saturation point of the hold counter.
  localparam logic [15:0] HOLD_CAP = 16'd60000;

  // Configuration register indexes.
  localparam int unsigned CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLD_TICKS  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DWELL_TICKS = 2'd1;

  localparam logic [15:0] HOLD_TICKS_RST  = 16'd48000;
  localparam logic [15:0] DWELL_TICKS_RST = 16'd2400;

  localparam int unsigned KNOB_W = 12;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 32;

  typedef struct packed {
    logic [1:0]        switch_pos;
    logic [KNOB_W-1:0] knob_value;
    logic              boot_settled;
  } psmc_item_t;

  typedef struct packed {
    logic [1:0]        prev_switch;
    logic [15:0]       hold_count;
    logic              toggle_armed;
    logic              setup_mode;
    logic [SLOT_W-1:0] committed_slot;
    logic [SLOT_W-1:0] pending_slot;
    logic [15:0]       dwell_count;
  } psmc_state_t;

  typedef struct packed {
    logic              mode;
    logic [SLOT_W-1:0] current_slot;
    logic              enter_setup;
    logic              exit_discard;
    logic              exit_save;
    logic              slot_committed;
    logic [1:0]        flash_kind;
    logic [13:0]       flash_ticks;
    logic [SLOT_W-1:0] show_number;
  } psmc_result_t;

endpackage

// ===== rtl/panel_setup_mode_controller_top.sv =====
// ----------------------------------------------------------------------------
// Panel setup-mode controller
// Per-tick mode machine driven by the panel switch and the main knob.
//
//   Channel  Dir  Width  Contents (low bit first)
//   s_axis   in   16     switch_pos[1:0], knob_value[13:2], boot_settled[14]
//   m_axis   out  32     mode, current_slot, enter_setup, exit_discard,
//                        exit_save, slot_committed, flash_kind, flash_ticks,
//                        show_number
//   cfg      in   16     hold_ticks (index 0), dwell_ticks (index 1)
//
// One request per cycle is sustained while the output is not stalled; each
// request passes the input register, then the tick update, into the result register.
// The controller state is updated as the request moves to the result register.
// Reset clears state (last switch Middle) and loads defaults; no clearing pass.
// A stalled output holds its result and stops the input register behind it.
// ----------------------------------------------------------------------------
module panel_setup_mode_controller_top #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // switch_pos[1:0], knob_value[13:2], boot_settled[14], zero[15]
  input  logic [psmc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // mode[0], current_slot[4:1], enter_setup[5], exit_discard[6], exit_save[7],
  // slot_committed[8], flash_kind[10:9], flash_ticks[24:11],
  // show_number[28:25], zero[31:29]
  output logic [psmc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [psmc_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [15:0]                         cfg_wdata_i
);
  import psmc_pkg::*;

  logic         in_valid_q;
  psmc_item_t   in_item_q;
  psmc_state_t  state_q, state_d;
  psmc_result_t res_d, res_q;
  logic         out_valid_q;
  logic [15:0]  hold_ticks_q, dwell_ticks_q;
  logic         out_free;
  logic         advance;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  psmc_step #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_step (
    .item_i        (in_item_q),
    .state_i       (state_q),
    .hold_ticks_i  (hold_ticks_q),
    .dwell_ticks_i (dwell_ticks_q),
    .state_o       (state_d),
    .result_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q  <= HOLD_TICKS_RST;
      dwell_ticks_q <= DWELL_TICKS_RST;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == REG_HOLD_TICKS) begin
        hold_ticks_q <= cfg_wdata_i;
      end
      if (cfg_addr_i == REG_DWELL_TICKS) begin
        dwell_ticks_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{prev_switch: SW_MIDDLE, default: '0};
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.switch_pos   <= s_axis_tdata[1:0];
      in_item_q.knob_value   <= s_axis_tdata[13:2];
      in_item_q.boot_settled <= s_axis_tdata[14];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q.show_number, res_q.flash_ticks, res_q.flash_kind,
                          res_q.slot_committed, res_q.exit_save, res_q.exit_discard,
                          res_q.enter_setup, res_q.current_slot, res_q.mode};

  // At most one event fires per tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0({res_q.enter_setup, res_q.exit_discard,
                              res_q.exit_save, res_q.slot_committed}))
    else $error("more than one event in one result");

  // The reported mode agrees with the event that changed it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.enter_setup || res_q.exit_discard || res_q.exit_save) |->
      (res_q.mode == res_q.enter_setup))
    else $error("mode disagrees with mode event");

  // A flash length is given exactly when a flash starts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((res_q.flash_kind == FLASH_NONE) == (res_q.flash_ticks == '0)))
    else $error("flash kind and length disagree");

  // The hold counter never passes its cap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.hold_count <= HOLD_CAP)
    else $error("hold count above cap");

  // The controller state only moves when a request is passed to the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without a request");

endmodule

// ===== rtl/psmc_step.sv =====
// ----------------------------------------------------------------------------
// Panel setup-mode controller tick update
// Computes the next controller state and the result of one tick.
// ----------------------------------------------------------------------------
module psmc_step #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  psmc_pkg::psmc_item_t   item_i,
  input  psmc_pkg::psmc_state_t  state_i,
  input  logic [15:0]            hold_ticks_i,
  input  logic [15:0]            dwell_ticks_i,
  output psmc_pkg::psmc_state_t  state_o,
  output psmc_pkg::psmc_result_t result_o
);
  import psmc_pkg::*;

  localparam int unsigned MulW = KNOB_W + $clog2(NUM_SLOTS + 1);
  localparam int unsigned RawW = MulW - KNOB_W;

  logic [15:0]       hold_base;
  logic              armed;
  logic              toggle;
  logic [MulW-1:0]   knob_prod;
  logic [RawW-1:0]   raw_wide;
  logic [SLOT_W-1:0] raw_slot;
  logic [15:0]       dwell_inc;

  // Knob scaled to a slot: a constant multiply and a shift by the converter range.
  assign knob_prod = MulW'(item_i.knob_value) * MulW'(NUM_SLOTS);
  assign raw_wide  = knob_prod[MulW-1:KNOB_W];
  assign raw_slot  = (raw_wide >= RawW'(NUM_SLOTS)) ? SLOT_W'(NUM_SLOTS - 1)
                                                    : SLOT_W'(raw_wide);

  always_comb begin
    state_o   = state_i;
    result_o  = '0;
    hold_base = state_i.hold_count;
    armed     = state_i.toggle_armed;
    toggle    = 1'b0;
    dwell_inc = state_i.dwell_count + 16'd1;

    if (item_i.switch_pos == SW_DOWN) begin
      // A fresh press restarts the count and arms one toggle.
      if (state_i.prev_switch != SW_DOWN) begin
        hold_base = '0;
        armed     = 1'b1;
      end
      state_o.hold_count   = (hold_base < HOLD_CAP) ? hold_base + 16'd1 : hold_base;
      state_o.toggle_armed = armed;
      toggle = armed && (state_o.hold_count == hold_ticks_i) && item_i.boot_settled;
      if (toggle) begin
        state_o.toggle_armed = 1'b0;
        if (!state_i.setup_mode) begin
          state_o.setup_mode   = 1'b1;
          result_o.enter_setup = 1'b1;
          result_o.flash_kind  = FLASH_ENTER;
          result_o.flash_ticks = FLASH_ENTER_TICKS;
          state_o.pending_slot = state_i.committed_slot;
          state_o.dwell_count  = '0;
          result_o.show_number = state_i.committed_slot;
        end else begin
          state_o.setup_mode    = 1'b0;
          result_o.exit_discard = 1'b1;
          result_o.flash_kind   = FLASH_LEAVE;
          result_o.flash_ticks  = FLASH_LEAVE_TICKS;
        end
      end
    end else begin
      state_o.hold_count = '0;
    end

    if (state_o.setup_mode && item_i.switch_pos == SW_MIDDLE &&
        state_i.prev_switch == SW_UP) begin
      state_o.setup_mode   = 1'b0;
      result_o.exit_save   = 1'b1;
      result_o.flash_kind  = FLASH_LEAVE;
      result_o.flash_ticks = FLASH_LEAVE_TICKS;
      result_o.show_number = '0;
    end
    state_o.prev_switch = item_i.switch_pos;

    if (state_o.setup_mode) begin
      dwell_inc = state_o.dwell_count + 16'd1;
      if (raw_slot != state_o.committed_slot) begin
        if (raw_slot != state_o.pending_slot) begin
          state_o.pending_slot = raw_slot;
          state_o.dwell_count  = '0;
        end else if (dwell_inc >= dwell_ticks_i) begin
          state_o.committed_slot  = raw_slot;
          state_o.dwell_count     = '0;
          result_o.slot_committed = 1'b1;
          result_o.show_number    = raw_slot;
        end else begin
          state_o.dwell_count = dwell_inc;
        end
      end else begin
        state_o.pending_slot = raw_slot;
        state_o.dwell_count  = '0;
      end
    end

    result_o.mode         = state_o.setup_mode;
    result_o.current_slot = state_o.committed_slot;
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Panel setup-mode controller testbench
// Drives switch/knob ticks through the input stream while an internal
// predictor of the mode machine computes the expected result of every
// accepted tick. The output stream is checked field by field against those
// predictions. Random gaps and stalls fall on both sides of the block, and
// the hold and dwell registers are rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import psmc_pkg::*;

  localparam int unsigned NSLOTS = 16;
  // Switch code that matches no panel position.
  localparam logic [1:0] SW_NONE = 2'd3;
  localparam int unsigned LONG_HOLD_OFF = 300;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [15:0]           cfg_wdata_i = '0;

  panel_setup_mode_controller_top #(
    .NUM_SLOTS(NSLOTS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // Predicted controller state and register copies.
  logic [1:0]  sw_last   = SW_MIDDLE;
  logic [15:0] hold_cnt  = '0;
  logic        armed     = 1'b0;
  logic        in_setup  = 1'b0;
  logic [3:0]  slot_now  = '0;
  logic [3:0]  slot_cand = '0;
  logic [15:0] dwell_cnt = '0;
  logic [15:0] cfg_hold  = HOLD_TICKS_RST;
  logic [15:0] cfg_dwell = DWELL_TICKS_RST;

  logic [IN_DATA_W-1:0] switch_ticks_q[$];
  psmc_result_t         due_results[$];

  logic        in_fire = 1'b0;
  int unsigned src_gap = 0;
  int unsigned sink_wait = 0;
  int unsigned hold_off_asks = 0;
  int unsigned hold_off_seen = 0;
  bit          calm = 1'b0;
  int unsigned errors = 0;
  int unsigned ticks_checked = 0;
  int unsigned n_enter = 0, n_discard = 0, n_save = 0, n_commit = 0;
  int unsigned n_settings = 1;
  int unsigned set_hold = HOLD_TICKS_RST;
  int unsigned set_dwell = DWELL_TICKS_RST;

  int unsigned ph_hold  [7] = '{1, 3, 2, 5, 4, 1, 6};
  int unsigned ph_dwell [7] = '{0, 2, 1, 4, 0, 3, 5};

  function automatic psmc_result_t panel_tick(logic [1:0] sw, logic [11:0] knob,
                                              logic settled);
    psmc_result_t r;
    int unsigned  slot_raw;
    logic [3:0]   slot_q;
    r = '0;
    if (sw == SW_DOWN) begin
      if (sw_last != SW_DOWN) begin
        hold_cnt = '0;
        armed = 1'b1;
      end
      if (hold_cnt < HOLD_CAP) hold_cnt = hold_cnt + 16'd1;
      if (armed && hold_cnt == cfg_hold && settled) begin
        armed = 1'b0;
        if (!in_setup) begin
          in_setup = 1'b1;
          r.enter_setup = 1'b1;
          r.flash_kind = FLASH_ENTER;
          r.flash_ticks = FLASH_ENTER_TICKS;
          slot_cand = slot_now;
          dwell_cnt = '0;
          r.show_number = slot_now;
        end else begin
          in_setup = 1'b0;
          r.exit_discard = 1'b1;
          r.flash_kind = FLASH_LEAVE;
          r.flash_ticks = FLASH_LEAVE_TICKS;
        end
      end
    end else begin
      hold_cnt = '0;
    end

    if (in_setup && sw == SW_MIDDLE && sw_last == SW_UP) begin
      in_setup = 1'b0;
      r.exit_save = 1'b1;
      r.flash_kind = FLASH_LEAVE;
      r.flash_ticks = FLASH_LEAVE_TICKS;
      r.show_number = '0;
    end
    sw_last = sw;

    if (in_setup) begin
      slot_raw = (int'(knob) * NSLOTS) / 4096;
      if (slot_raw >= NSLOTS) slot_raw = NSLOTS - 1;
      slot_q = slot_raw[3:0];
      if (slot_q != slot_now) begin
        if (slot_q != slot_cand) begin
          slot_cand = slot_q;
          dwell_cnt = '0;
        end else begin
          dwell_cnt = dwell_cnt + 16'd1;
          if (dwell_cnt >= cfg_dwell) begin
            slot_now = slot_q;
            dwell_cnt = '0;
            r.slot_committed = 1'b1;
            r.show_number = slot_q;
          end
        end
      end else begin
        slot_cand = slot_q;
        dwell_cnt = '0;
      end
    end

    r.mode = in_setup;
    r.current_slot = slot_now;
    return r;
  endfunction

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Predictor, register mirror and output checker.
  always @(posedge clk_i) begin
    psmc_result_t want;
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_HOLD_TICKS: begin
          cfg_hold = cfg_wdata_i;
        end
        REG_DWELL_TICKS: begin
          cfg_dwell = cfg_wdata_i;
        end
        default: begin
        end
      endcase
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      due_results.push_back(panel_tick(s_axis_tdata[1:0], s_axis_tdata[13:2],
                                       s_axis_tdata[14]));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual 0x%08h", $time,
                 m_axis_tdata);
        errors++;
      end else begin
        want = due_results.pop_front();
        ticks_checked++;
        n_enter   += want.enter_setup;
        n_discard += want.exit_discard;
        n_save    += want.exit_save;
        n_commit  += want.slot_committed;
        check_field("mode",           want.mode,           m_axis_tdata[0]);
        check_field("current_slot",   want.current_slot,   m_axis_tdata[4:1]);
        check_field("enter_setup",    want.enter_setup,    m_axis_tdata[5]);
        check_field("exit_discard",   want.exit_discard,   m_axis_tdata[6]);
        check_field("exit_save",      want.exit_save,      m_axis_tdata[7]);
        check_field("slot_committed", want.slot_committed, m_axis_tdata[8]);
        check_field("flash_kind",     want.flash_kind,     m_axis_tdata[10:9]);
        check_field("flash_ticks",    want.flash_ticks,    m_axis_tdata[24:11]);
        check_field("show_number",    want.show_number,    m_axis_tdata[28:25]);
      end
    end
  end

  // Tick driver: holds a request until it is taken, then may insert a gap.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (src_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (switch_ticks_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= switch_ticks_q.pop_front();
        src_gap <= (!calm && $urandom_range(0, 99) < 25) ? idle_len() : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result sink with random stalls and an occasional long hold-off.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off_asks != hold_off_seen) begin
      hold_off_seen <= hold_off_asks;
      sink_wait <= LONG_HOLD_OFF;
      m_axis_tready <= 1'b0;
    end else if (sink_wait > 0) begin
      sink_wait <= sink_wait - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 10) begin
      sink_wait <= idle_len();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic push_tick(logic [1:0] sw, logic [11:0] knob, logic boot);
    switch_ticks_q.push_back({1'b0, boot, knob, sw});
  endtask

  function automatic logic [11:0] slot_knob(int unsigned slot);
    logic [3:0] s;
    s = slot[3:0];
    return {s, 8'($urandom)};
  endfunction

  // Waits until no tick is queued or offered and every result has arrived.
  task automatic drain();
    forever begin
      @(posedge clk_i);
      #1;
      if (switch_ticks_q.size() == 0 && !s_axis_tvalid && due_results.size() == 0) break;
    end
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(int unsigned h, int unsigned d);
    drain();
    repeat (3) @(negedge clk_i);
    write_reg(REG_HOLD_TICKS, h[15:0]);
    write_reg(REG_DWELL_TICKS, d[15:0]);
    set_hold = h;
    set_dwell = d;
    n_settings++;
  endtask

  // One operator action: presses, saves, knob moves or plain noise.
  task automatic push_gesture(inout int unsigned count);
    int unsigned pick, n, m, slot;
    logic [11:0] knob;
    pick = $urandom_range(0, 99);
    slot = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) == 0) ? 0 : NSLOTS - 1)
                                       : $urandom_range(0, NSLOTS - 1);
    knob = slot_knob(slot);
    if (set_hold >= 1 && set_hold <= 20) n = set_hold;
    else n = $urandom_range(1, 20);
    if (pick < 30) begin
      n += $urandom_range(0, 2);
      m = $urandom_range(1, 3);
      repeat (n) push_tick(SW_DOWN, knob, $urandom_range(0, 19) != 0);
      repeat (m) push_tick(SW_MIDDLE, knob, 1'b1);
      count += n + m;
    end else if (pick < 45) begin
      n = (n > 1) ? $urandom_range(1, n - 1) : 1;
      repeat (n) push_tick(SW_DOWN, knob, 1'b1);
      push_tick(SW_MIDDLE, knob, 1'b1);
      count += n + 1;
    end else if (pick < 60) begin
      n = $urandom_range(1, 3);
      repeat (n) push_tick(SW_UP, knob, 1'b1);
      push_tick(SW_MIDDLE, knob, 1'b1);
      count += n + 1;
    end else if (pick < 85) begin
      n = ((set_dwell <= 20) ? set_dwell : 10) + $urandom_range(0, 3);
      repeat (n) push_tick(($urandom_range(0, 4) == 0) ? SW_UP : SW_MIDDLE,
                           slot_knob(slot), 1'b1);
      count += n;
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) push_tick(2'($urandom), 12'($urandom), 1'($urandom));
      count += n;
    end
  endtask

  task automatic random_phase(int unsigned n_items);
    int unsigned count;
    count = 0;
    while (count < n_items) push_gesture(count);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Field extremes and the invalid switch code under the reset registers.
    push_tick(SW_MIDDLE, 12'h000, 1'b0);
    push_tick(SW_UP, 12'hFFF, 1'b1);
    push_tick(SW_NONE, 12'hFFF, 1'b1);
    push_tick(SW_MIDDLE, 12'h800, 1'b0);
    push_tick(SW_DOWN, 12'h000, 1'b0);
    push_tick(SW_DOWN, 12'hFFF, 1'b1);

    set_regs(2, 1);
    // The matching hold tick while boot is unsettled spends the press.
    push_tick(SW_MIDDLE, 12'h000, 1'b1);
    push_tick(SW_DOWN, 12'h000, 1'b1);
    push_tick(SW_DOWN, 12'h000, 1'b0);
    push_tick(SW_DOWN, 12'h000, 1'b1);
    push_tick(SW_MIDDLE, 12'h000, 1'b1);
    // Enter setup, move to the top slot and commit it, then save.
    push_tick(SW_DOWN, 12'h000, 1'b1);
    push_tick(SW_DOWN, 12'h000, 1'b1);
    push_tick(SW_MIDDLE, 12'hFFF, 1'b1);
    push_tick(SW_MIDDLE, 12'hFFF, 1'b1);
    push_tick(SW_UP, 12'h000, 1'b1);
    push_tick(SW_MIDDLE, 12'h000, 1'b1);
    // Re-enter; Up then invalid then Middle must not save; leave by hold.
    push_tick(SW_DOWN, 12'hF00, 1'b1);
    push_tick(SW_DOWN, 12'hF00, 1'b1);
    push_tick(SW_UP, 12'hF00, 1'b1);
    push_tick(SW_NONE, 12'hF00, 1'b1);
    push_tick(SW_MIDDLE, 12'hF00, 1'b1);
    push_tick(SW_DOWN, 12'h0FF, 1'b1);
    push_tick(SW_DOWN, 12'h0FF, 1'b1);
    push_tick(SW_MIDDLE, 12'h0FF, 1'b1);

    for (int i = 0; i < 7; i++) begin
      set_regs(ph_hold[i], ph_dwell[i]);
      calm = (i == 2);
      random_phase(180);
      // Let the sender keep offering while the sink refuses for a while.
      if (i == 3) hold_off_asks++;
    end
    calm = 1'b0;

    // Out-of-range and extreme register values.
    set_regs(0, 65535);
    random_phase(60);
    set_regs(65535, 0);
    random_phase(60);
    // A hold setting at the counter cap that short presses never reach.
    set_regs(60000, 1);
    random_phase(40);

    drain();
    repeat (10) @(posedge clk_i);
    $display("Checked %0d ticks across %0d register settings.", ticks_checked, n_settings);
    $display("Saw %0d setup entries, %0d discards, %0d saves and %0d slot commits.",
             n_enter, n_discard, n_save, n_commit);
    if (errors == 0) begin
      $display("** panel_setup_mode_controller_top: PASSED **");
    end else begin
      $display("** panel_setup_mode_controller_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Timeout with %0d results still due.", due_results.size());
    $display("** panel_setup_mode_controller_top: FAILED **");
    $finish;
  end

endmodule
